FILE: hdl/tlr_pkg.sv
// Shared types, sizes and command codes for the thick line rasterizer.
// No dependencies; tlr_stamp, the rasterizer top and the bench import this package.
`default_nettype none

package tlr_pkg;

   // frame and brush geometry
   localparam int FRAME_WIDTH  = 240;
   localparam int FRAME_HEIGHT = 240;
   localparam int MAX_BRUSH    = 24;
   localparam int BOX_MARGIN   = 2;

   // derived sizes
   localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int XW     = $clog2(FRAME_WIDTH);
   localparam int YW     = $clog2(FRAME_HEIGHT);
   localparam int AW     = $clog2(DEPTH);
   localparam int RW     = $clog2(MAX_BRUSH / 2 + 1);
   localparam int OW     = RW + 1;
   localparam int SQW    = 2 * OW + 1;
   localparam int MAXDIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
   localparam int CW     = $clog2(MAXDIM + MAX_BRUSH) + 3;

   // command codes
   localparam logic [1:0] CMD_DRAW  = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // register index taken from paddr[2]
   localparam logic REG_BACKGROUND = 1'b0;

   // segment handed to the stamp engine
   typedef struct packed {
      logic [XW-1:0] x0;
      logic [YW-1:0] y0;
      logic [XW-1:0] x1;
      logic [YW-1:0] y1;
      logic [RW-1:0] radius;
   } stamp_cmd_type;

   // pixel writes coming back from the stamp engine
   typedef struct packed {
      logic          en;
      logic [AW-1:0] addr;
      logic          done;
   } stamp_wr_type;

   // clamp a signed 12-bit coordinate into 0..hi
   function automatic logic [11:0] clamp_coord(input logic signed [11:0] v, input int hi);
      logic [11:0] res;
      if (v < 0) begin
         res = '0;
      end else if (int'(v) > hi) begin
         res = 12'(hi);
      end else begin
         res = v;
      end
      return res;
   endfunction

   // brush width clamped to 1..MAX_BRUSH, halved, at least one
   function automatic logic [RW-1:0] radius_of(input logic [7:0] bw);
      logic [7:0] w;
      logic [7:0] r;
      if (bw == 8'd0) begin
         w = 8'd1;
      end else if (bw > 8'(MAX_BRUSH)) begin
         w = 8'(MAX_BRUSH);
      end else begin
         w = bw;
      end
      r = w >> 1;
      if (r == 8'd0) begin
         r = 8'd1;
      end
      return RW'(r);
   endfunction

   // clamp a box edge into 0..hi and keep the low eight bits
   function automatic logic [7:0] clamp_box(input logic signed [CW-1:0] v, input int hi);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > hi) begin
         res = 8'(hi);
      end else begin
         res = 8'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/tlr_req_if.sv
// Command channel of the thick line rasterizer: valid/ready plus one command word.
// No dependencies.
`default_nettype none

interface tlr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [11:0] start_x;
   logic signed [11:0] start_y;
   logic signed [11:0] end_x;
   logic signed [11:0] end_y;
   logic [15:0]        brush_color;
   logic [7:0]         brush_width;

   modport source (
      output valid, cmd, start_x, start_y, end_x, end_y, brush_color, brush_width,
      input  ready
   );

   modport sink (
      input  valid, cmd, start_x, start_y, end_x, end_y, brush_color, brush_width,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/tlr_rsp_if.sv
// Result channel of the thick line rasterizer: valid/ready plus one result word.
// No dependencies.
`default_nettype none

interface tlr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  dirty_left;
   logic [7:0]  dirty_right;
   logic [7:0]  dirty_top;
   logic [7:0]  dirty_bottom;
   logic [15:0] pixel_value;
   logic        has_drawing;

   modport source (
      output valid, dirty_left, dirty_right, dirty_top, dirty_bottom, pixel_value,
      output has_drawing,
      input  ready
   );

   modport sink (
      input  valid, dirty_left, dirty_right, dirty_top, dirty_bottom, pixel_value,
      input  has_drawing,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/tlr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module tlr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/tlr_stamp.sv
// Stamp engine: walks a Bresenham segment and scans a filled disk at every step,
// producing one frame store write address per cycle. Depends on tlr_pkg.
`default_nettype none

module tlr_stamp import tlr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire stamp_cmd_type cmd,
   output      stamp_wr_type  wr
);

   // walker state
   logic                  active_ff, active_in;
   logic signed [CW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [CW-1:0]  x1_ff, x1_in, y1_ff, y1_in;
   logic signed [CW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [CW-1:0]  err_ff, err_in;
   logic                  sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic signed [OW-1:0]  ox_ff, ox_in, oy_ff, oy_in, rad_ff, rad_in;
   logic signed [SQW-1:0] rsq_ff, rsq_in;

   // disk test stage
   logic                  pa_v_ff, pa_last_ff, pa_ok_ff;
   logic signed [CW-1:0]  pa_x_ff, pa_y_ff;

   // write stage
   logic                  wr_en_ff, done_ff;
   logic [AW-1:0]         wr_addr_ff;

   logic signed [CW-1:0]  sx0, sy0, sx1, sy1, e2;
   logic signed [OW-1:0]  rad_new;
   logic signed [SQW-1:0] rad_w, ox_w, oy_w, ox_sq, oy_sq;
   logic                  ox_end, oy_end, at_end, step_x, step_y, in_disk, in_frame;

   // segment setup values
   always_comb begin
      sx0     = CW'(cmd.x0);
      sy0     = CW'(cmd.y0);
      sx1     = CW'(cmd.x1);
      sy1     = CW'(cmd.y1);
      rad_new = signed'({1'b0, cmd.radius});
      rad_w   = SQW'(rad_new);
   end

   // disk membership and walk decisions
   always_comb begin
      ox_w    = SQW'(ox_ff);
      oy_w    = SQW'(oy_ff);
      ox_sq   = ox_w * ox_w;
      oy_sq   = oy_w * oy_w;
      in_disk = (ox_sq + oy_sq) <= rsq_ff;
      ox_end  = (ox_ff == rad_ff);
      oy_end  = (oy_ff == rad_ff);
      at_end  = (x_ff == x1_ff) && (y_ff == y1_ff);
      e2      = err_ff <<< 1;
      step_x  = e2 > -dy_ff;
      step_y  = e2 < dx_ff;
   end

   // next walker state
   always_comb begin
      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      err_in    = err_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      rad_in    = rad_ff;
      rsq_in    = rsq_ff;
      if (start) begin
         active_in = 1'b1;
         x_in      = sx0;
         y_in      = sy0;
         x1_in     = sx1;
         y1_in     = sy1;
         dx_in     = (sx1 > sx0) ? sx1 - sx0 : sx0 - sx1;
         dy_in     = (sy1 > sy0) ? sy1 - sy0 : sy0 - sy1;
         err_in    = dx_in - dy_in;
         sx_neg_in = !(sx0 < sx1);
         sy_neg_in = !(sy0 < sy1);
         rad_in    = rad_new;
         rsq_in    = rad_w * rad_w;
         ox_in     = -rad_new;
         oy_in     = -rad_new;
      end else if (active_ff) begin
         if (!ox_end) begin
            ox_in = ox_ff + OW'(1);
         end else begin
            ox_in = -rad_ff;
            if (!oy_end) begin
               oy_in = oy_ff + OW'(1);
            end else begin
               oy_in = -rad_ff;
               if (at_end) begin
                  active_in = 1'b0;
               end else begin
                  // one Bresenham step
                  err_in = err_ff - (step_x ? dy_ff : CW'(0)) + (step_y ? dx_ff : CW'(0));
                  if (step_x) begin
                     x_in = sx_neg_ff ? x_ff - CW'(1) : x_ff + CW'(1);
                  end
                  if (step_y) begin
                     y_in = sy_neg_ff ? y_ff - CW'(1) : y_ff + CW'(1);
                  end
               end
            end
         end
      end
   end

   // walker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      err_ff    <= err_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      rad_ff    <= rad_in;
      rsq_ff    <= rsq_in;
   end

   // disk test stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pa_v_ff    <= 1'b0;
         pa_last_ff <= 1'b0;
      end else begin
         pa_v_ff    <= active_ff;
         pa_last_ff <= active_ff && ox_end && oy_end && at_end;
      end
      pa_ok_ff <= in_disk;
      pa_x_ff  <= x_ff + CW'(ox_ff);
      pa_y_ff  <= y_ff + CW'(oy_ff);
   end

   // clip to the frame and form the linear address
   always_comb begin
      in_frame = (pa_x_ff >= 0) && (pa_x_ff < FRAME_WIDTH) &&
                 (pa_y_ff >= 0) && (pa_y_ff < FRAME_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         wr_en_ff <= pa_v_ff && pa_ok_ff && in_frame;
         done_ff  <= pa_last_ff;
      end
      wr_addr_ff <= AW'(pa_y_ff[YW-1:0]) * AW'(FRAME_WIDTH) + AW'(pa_x_ff[XW-1:0]);
   end

   assign wr.en   = wr_en_ff;
   assign wr.addr = wr_addr_ff;
   assign wr.done = done_ff;

endmodule

`default_nettype wire

FILE: hdl/thick_line_rasterizer.sv
// Thick line rasterizer: a draw stamps a disk at each of the max(|dx|, |dy|) + 1
// points of the clamped segment, scanning (2r + 1)^2 positions per disk, one per cycle
// through the store's single write port; clear writes one word per cycle. One word is
// worked on at a time; a finished result waits in the output register while the next
// word is taken. After reset all DEPTH words of the store (57600 at 240x240) are swept
// to zero with req_chan.ready low; the csr port works throughout.
// Depends on tlr_pkg, tlr_req_if, tlr_rsp_if, tlr_ram and tlr_stamp.
`default_nettype none

module thick_line_rasterizer import tlr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   tlr_req_if.sink          req_chan,
   tlr_rsp_if.source        rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   // sequencer states
   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DSTART = 3'd2;
   localparam logic [2:0] ST_DRAW   = 3'd3;
   localparam logic [2:0] ST_CLEAR  = 3'd4;
   localparam logic [2:0] ST_RADDR  = 3'd5;
   localparam logic [2:0] ST_RDATA  = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          flag_ff, flag_in;
   logic [15:0]   bg_ff;

   // captured command word
   logic [1:0]    cmd_ff;
   logic [XW-1:0] cx0_ff, cx1_ff;
   logic [YW-1:0] cy0_ff, cy1_ff;
   logic [RW-1:0] rad_ff;
   logic [15:0]   color_ff;
   logic [15:0]   pix_ff;

   // output register
   logic          rsp_valid_ff;
   logic [7:0]    out_left_ff, out_right_ff, out_top_ff, out_bottom_ff;
   logic [15:0]   out_pixel_ff;
   logic          out_flag_ff;

   logic          accept, out_free, load_out, clr_last, csr_write;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [15:0]   ram_wdata, ram_rdata;
   stamp_cmd_type stamp_cmd;
   stamp_wr_type  stamp_wr;
   logic [XW-1:0] min_x, max_x;
   logic [YW-1:0] min_y, max_y;
   logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;

   // config register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff <= '0;
      end else if (csr_write && (paddr[2] == REG_BACKGROUND)) begin
         bg_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_BACKGROUND) begin
         prdata = {16'd0, bg_ff};
      end
   end

   // handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign load_out       = (state_ff == ST_DONE) && out_free;
   assign clr_last       = (clr_ff == AW'(DEPTH - 1));

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      flag_in  = flag_ff;
      case (state_ff)
         ST_INIT: begin
            clr_in = clr_ff + AW'(1);
            if (clr_last) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_DRAW: begin
                     flag_in  = 1'b1;
                     state_in = ST_DSTART;
                  end
                  CMD_CLEAR: begin
                     flag_in  = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: begin
                     state_in = ST_RADDR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DSTART: begin
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (stamp_wr.done) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_last) begin
               clr_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_RADDR: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         clr_ff   <= '0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         flag_ff  <= flag_in;
      end
   end

   // capture the clamped command word
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_chan.cmd;
         cx0_ff   <= XW'(clamp_coord(req_chan.start_x, FRAME_WIDTH - 1));
         cy0_ff   <= YW'(clamp_coord(req_chan.start_y, FRAME_HEIGHT - 1));
         cx1_ff   <= XW'(clamp_coord(req_chan.end_x, FRAME_WIDTH - 1));
         cy1_ff   <= YW'(clamp_coord(req_chan.end_y, FRAME_HEIGHT - 1));
         rad_ff   <= radius_of(req_chan.brush_width);
         color_ff <= req_chan.brush_color;
      end
      if (state_ff == ST_RDATA) begin
         pix_ff <= ram_rdata;
      end
   end

   // stamp engine
   assign stamp_cmd.x0     = cx0_ff;
   assign stamp_cmd.y0     = cy0_ff;
   assign stamp_cmd.x1     = cx1_ff;
   assign stamp_cmd.y1     = cy1_ff;
   assign stamp_cmd.radius = rad_ff;

   tlr_stamp u_stamp (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DSTART),
      .cmd   (stamp_cmd),
      .wr    (stamp_wr)
   );

   // frame store port selection
   always_comb begin
      if (state_ff == ST_INIT || state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = (state_ff == ST_INIT) ? 16'd0 : bg_ff;
      end else begin
         ram_we    = stamp_wr.en;
         ram_waddr = stamp_wr.addr;
         ram_wdata = color_ff;
      end
      ram_re    = (state_ff == ST_RADDR);
      ram_raddr = AW'(cy0_ff) * AW'(FRAME_WIDTH) + AW'(cx0_ff);
   end

   tlr_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // dirty rectangle from the endpoint box
   always_comb begin
      min_x = (cx0_ff < cx1_ff) ? cx0_ff : cx1_ff;
      max_x = (cx0_ff > cx1_ff) ? cx0_ff : cx1_ff;
      min_y = (cy0_ff < cy1_ff) ? cy0_ff : cy1_ff;
      max_y = (cy0_ff > cy1_ff) ? cy0_ff : cy1_ff;
      lo_x  = CW'(min_x) - CW'(rad_ff) - CW'(BOX_MARGIN);
      hi_x  = CW'(max_x) + CW'(rad_ff) + CW'(BOX_MARGIN);
      lo_y  = CW'(min_y) - CW'(rad_ff) - CW'(BOX_MARGIN);
      hi_y  = CW'(max_y) + CW'(rad_ff) + CW'(BOX_MARGIN);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         out_left_ff   <= (cmd_ff == CMD_DRAW) ? clamp_box(lo_x, FRAME_WIDTH - 1) : 8'd0;
         out_right_ff  <= (cmd_ff == CMD_DRAW) ? clamp_box(hi_x, FRAME_WIDTH - 1) : 8'd0;
         out_top_ff    <= (cmd_ff == CMD_DRAW) ? clamp_box(lo_y, FRAME_HEIGHT - 1) : 8'd0;
         out_bottom_ff <= (cmd_ff == CMD_DRAW) ? clamp_box(hi_y, FRAME_HEIGHT - 1) : 8'd0;
         out_pixel_ff  <= (cmd_ff == CMD_READ) ? pix_ff : 16'd0;
         out_flag_ff   <= flag_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.dirty_left   = out_left_ff;
   assign rsp_chan.dirty_right  = out_right_ff;
   assign rsp_chan.dirty_top    = out_top_ff;
   assign rsp_chan.dirty_bottom = out_bottom_ff;
   assign rsp_chan.pixel_value  = out_pixel_ff;
   assign rsp_chan.has_drawing  = out_flag_ff;

   // checks
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr < AW'(DEPTH)))
      else $error("frame store write beyond depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !ram_we)
      else $error("frame store written while no command is at work");

   a_done_in_draw: assert property (@(posedge clock) disable iff (reset)
      stamp_wr.done |-> (state_ff == ST_DRAW))
      else $error("stamp engine finished outside a draw");

   a_clear_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.cmd == CMD_CLEAR) |=> (state_ff == ST_CLEAR && clr_ff == '0))
      else $error("clear sweep did not start at the first word");

endmodule

`default_nettype wire

FILE: verif/tb_thick_line_rasterizer.sv
// Self-checking bench for thick_line_rasterizer: sends draw, clear, read and unused words,
// writes the background register over csr, and checks every result word against a canvas model.
// Depends on tlr_pkg, tlr_req_if, tlr_rsp_if and the rasterizer RTL.
module tb_thick_line_rasterizer;
   import tlr_pkg::*;

   localparam int         HALF_PERIOD     = 5;
   localparam int         RESET_CYCLES    = 10;
   localparam int         PHASE_WORDS     = 186;
   localparam int         HOLD_OFF_CYCLES = 3000;
   localparam int         TAIL_CYCLES     = 64;
   localparam int         LIMIT_CYCLES    = 15_000_000;
   localparam int         COORD_MIN       = -2048;
   localparam int         COORD_MAX       = 2047;
   localparam logic [1:0] CMD_UNUSED      = 2'd3;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [11:0] start_x;
      logic signed [11:0] start_y;
      logic signed [11:0] end_x;
      logic signed [11:0] end_y;
      logic [15:0]        brush_color;
      logic [7:0]         brush_width;
   } command_type;

   typedef struct {
      logic [7:0]  dirty_left;
      logic [7:0]  dirty_right;
      logic [7:0]  dirty_top;
      logic [7:0]  dirty_bottom;
      logic [15:0] pixel_value;
      logic        has_drawing;
   } result_type;

   // receiver stall patterns
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_type;

   // canvas model: frame store, drawn flag and the queue of result words still owed
   class canvas_model;
      bit [15:0]  pixels [DEPTH];
      bit         drawn;
      bit [15:0]  background;
      result_type awaited_results[$];
      int         mismatch_count;

      function new();
         background     = '0;
         drawn          = 1'b0;
         mismatch_count = 0;
         paint_background();
      endfunction

      function void paint_background();
         foreach (pixels[i]) pixels[i] = background;
      endfunction

      function int clip(input int v, input int lo, input int hi);
         return (v < lo) ? lo : (v > hi) ? hi : v;
      endfunction

      // filled disk, pixels outside the frame dropped
      function void stamp(input int cx, input int cy, input int r, input bit [15:0] c);
         int x, y;
         for (y = cy - r; y <= cy + r; y++) begin
            for (x = cx - r; x <= cx + r; x++) begin
               if (y >= 0 && y < FRAME_HEIGHT && x >= 0 && x < FRAME_WIDTH &&
                   (x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r) begin
                  pixels[y * FRAME_WIDTH + x] = c;
               end
            end
         end
      endfunction

      // apply one accepted command word and queue the result it owes
      function void take_command(input command_type c);
         result_type res;
         int         x0, y0, x1, y1, r, dx, dy, sx, sy, err, e2, x, y;
         res = '{default: '0};
         x0  = clip(int'(c.start_x), 0, FRAME_WIDTH - 1);
         y0  = clip(int'(c.start_y), 0, FRAME_HEIGHT - 1);
         case (c.cmd)
            CMD_DRAW: begin
               x1  = clip(int'(c.end_x), 0, FRAME_WIDTH - 1);
               y1  = clip(int'(c.end_y), 0, FRAME_HEIGHT - 1);
               r   = clip(int'(c.brush_width), 1, MAX_BRUSH) / 2;
               if (r < 1) r = 1;
               dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
               dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
               sx  = (x0 < x1) ? 1 : -1;
               sy  = (y0 < y1) ? 1 : -1;
               err = dx - dy;
               x   = x0;
               y   = y0;
               stamp(x, y, r, c.brush_color);
               // bresenham walk, one disk per step
               while (x != x1 || y != y1) begin
                  e2 = 2 * err;
                  if (e2 > -dy) begin
                     err -= dy;
                     x   += sx;
                  end
                  if (e2 < dx) begin
                     err += dx;
                     y   += sy;
                  end
                  stamp(x, y, r, c.brush_color);
               end
               drawn = 1'b1;
               res.dirty_left   = 8'(clip(((x0 < x1) ? x0 : x1) - r - BOX_MARGIN,
                                          0, FRAME_WIDTH - 1));
               res.dirty_right  = 8'(clip(((x0 > x1) ? x0 : x1) + r + BOX_MARGIN,
                                          0, FRAME_WIDTH - 1));
               res.dirty_top    = 8'(clip(((y0 < y1) ? y0 : y1) - r - BOX_MARGIN,
                                          0, FRAME_HEIGHT - 1));
               res.dirty_bottom = 8'(clip(((y0 > y1) ? y0 : y1) + r + BOX_MARGIN,
                                          0, FRAME_HEIGHT - 1));
            end
            CMD_CLEAR: begin
               paint_background();
               drawn = 1'b0;
            end
            CMD_READ: begin
               res.pixel_value = pixels[y0 * FRAME_WIDTH + x0];
            end
            default: begin
            end
         endcase
         res.has_drawing = drawn;
         awaited_results.push_back(res);
      endfunction

      function void compare_field(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
         end
      endfunction

      // compare one result word with the oldest one owed
      function void check_result(input result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: result word with nothing owed, expected none, actual pixel %0h",
                     $time, got.pixel_value);
            mismatch_count++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("dirty_left", 16'(want.dirty_left), 16'(got.dirty_left));
         compare_field("dirty_right", 16'(want.dirty_right), 16'(got.dirty_right));
         compare_field("dirty_top", 16'(want.dirty_top), 16'(got.dirty_top));
         compare_field("dirty_bottom", 16'(want.dirty_bottom), 16'(got.dirty_bottom));
         compare_field("pixel_value", want.pixel_value, got.pixel_value);
         compare_field("has_drawing", 16'(want.has_drawing), 16'(got.has_drawing));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tlr_req_if req_bus ();
   tlr_rsp_if rsp_bus ();

   canvas_model board = new();

   int burst_left    = 0;
   int items_sent    = 0;
   int hold_off_asked = 0;

   thick_line_rasterizer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic command_type pack_command(input logic [1:0] cmd, input int sx,
                                                input int sy, input int ex, input int ey,
                                                input int color, input int width);
      command_type c;
      c.cmd         = cmd;
      c.start_x     = 12'(sx);
      c.start_y     = 12'(sy);
      c.end_x       = 12'(ex);
      c.end_y       = 12'(ey);
      c.brush_color = 16'(color);
      c.brush_width = 8'(width);
      return c;
   endfunction

   // mostly in frame, some around the borders, a few anywhere in the 12-bit range
   function automatic int rand_anchor(input int span);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         return $urandom_range(0, span - 1);
      end else if (pick < 90) begin
         return int'($urandom_range(0, span + 59)) - 30;
      end
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   // random offset around base, saturated to the coordinate range
   function automatic int nudge(input int base, input int span);
      int v;
      v = base + int'($urandom_range(0, 2 * span)) - span;
      return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   // offer one word in bursts with random gaps, wait for the handshake
   task automatic issue(input command_type c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= c.cmd;
      req_bus.start_x     <= c.start_x;
      req_bus.start_y     <= c.start_y;
      req_bus.end_x       <= c.end_x;
      req_bus.end_y       <= c.end_y;
      req_bus.brush_color <= c.brush_color;
      req_bus.brush_width <= c.brush_width;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      board.take_command(c);
      items_sent++;
   endtask

   // sender pause until every owed result word is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.awaited_results.size() != 0);
   endtask

   // apb write of the background register, setup then access
   task automatic program_background(input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_BACKGROUND, 2'b00};
      pwdata  <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.background = value;
   endtask

   task automatic issue_read(input int x, input int y);
      issue(pack_command(CMD_READ, x, y, $urandom, $urandom, $urandom, $urandom));
   endtask

   // corner cases: field extremes, clipping, brush clamps, every command
   task automatic run_directed();
      issue_read(0, 0);
      issue(pack_command(CMD_UNUSED, 100, 100, 5, 5, 16'hABCD, 9));
      issue(pack_command(CMD_DRAW, -2048, -2048, 2047, 2047, 16'hFFFF, 0));
      issue_read(120, 120);
      issue_read(-2048, 2047);
      issue_read(2047, -2048);
      issue(pack_command(CMD_DRAW, 120, 40, 120, 40, 16'h5A5A, 255));
      issue_read(132, 40);
      issue_read(129, 49);
      issue(pack_command(CMD_DRAW, -5, -5, 6, 0, 16'h8001, 24));
      issue(pack_command(CMD_DRAW, 239, 239, 2047, 2047, 16'h0000, 23));
      // steep, shallow and diagonal lines in negative and positive directions
      issue(pack_command(CMD_DRAW, 200, 230, 190, 150, 16'h07E0, 1));
      issue(pack_command(CMD_DRAW, 230, 20, 150, 25, 16'hF800, 2));
      issue(pack_command(CMD_DRAW, 50, 200, 60, 190, 16'h001F, 5));
      issue(pack_command(CMD_DRAW, 10, 100, 12, 103, 16'h1234, 25));
      issue_read(0, 0);
      issue_read(239, 239);
      issue_read(195, 190);
      issue(pack_command(CMD_UNUSED, -1, -1, -1, -1, 16'hFFFF, 255));
      issue(pack_command(CMD_CLEAR, 2047, -2048, 0, 0, 16'hFFFF, 255));
      issue_read(120, 120);
      issue(pack_command(CMD_DRAW, 30, 30, 33, 31, 16'h0000, 3));
      issue_read(31, 30);
   endtask

   // random strokes: a draw followed by reads around it, with some noise between
   task automatic run_strokes(input int quota);
      int target, kind, seg, sx, sy, ex, ey, bw, reads;
      target = items_sent + quota;
      while (items_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            issue(pack_command(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom));
         end else if (kind < 12) begin
            issue_read(rand_anchor(FRAME_WIDTH), rand_anchor(FRAME_HEIGHT));
         end else if (kind < 14) begin
            drain();
         end else begin
            seg = $urandom_range(0, 99);
            if (seg < 70) begin
               // short stroke, thin brush
               sx = rand_anchor(FRAME_WIDTH);
               sy = rand_anchor(FRAME_HEIGHT);
               ex = nudge(sx, 8);
               ey = nudge(sy, 8);
               bw = $urandom_range(0, 8);
            end else if (seg < 90) begin
               // very short stroke, any brush width
               sx = rand_anchor(FRAME_WIDTH);
               sy = rand_anchor(FRAME_HEIGHT);
               ex = nudge(sx, 3);
               ey = nudge(sy, 3);
               bw = $urandom_range(0, 255);
            end else begin
               // long stroke across the frame, fine brush
               sx = $urandom_range(0, FRAME_WIDTH - 1);
               sy = $urandom_range(0, FRAME_HEIGHT - 1);
               ex = $urandom_range(0, FRAME_WIDTH - 1);
               ey = $urandom_range(0, FRAME_HEIGHT - 1);
               bw = $urandom_range(0, 4);
            end
            issue(pack_command(CMD_DRAW, sx, sy, ex, ey, $urandom, bw));
            reads = $urandom_range(0, 3);
            repeat (reads) begin
               if ($urandom_range(0, 1) == 1) begin
                  issue_read(nudge(sx, 14), nudge(sy, 14));
               end else begin
                  issue_read(nudge(ex, 14), nudge(ey, 14));
               end
            end
         end
      end
   endtask

   // long receiver hold-off while reads keep coming, so the block backs up
   task automatic squeeze_output();
      hold_off_asked++;
      burst_left = 16;
      repeat (14) issue_read($urandom_range(0, FRAME_WIDTH - 1),
                             $urandom_range(0, FRAME_HEIGHT - 1));
   endtask

   // stimulus
   initial begin
      logic [15:0] shade;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.cmd         <= CMD_DRAW;
      req_bus.start_x     <= '0;
      req_bus.start_y     <= '0;
      req_bus.end_x       <= '0;
      req_bus.end_y       <= '0;
      req_bus.brush_color <= '0;
      req_bus.brush_width <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain();

      // background phases: all ones, random, all zeros
      for (int phase = 0; phase < 3; phase++) begin
         shade = (phase == 0) ? 16'hFFFF : (phase == 1) ? 16'($urandom) : 16'h0000;
         program_background(shade);
         // old contents stay until the clear
         repeat (3) issue_read($urandom_range(0, FRAME_WIDTH - 1),
                               $urandom_range(0, FRAME_HEIGHT - 1));
         issue(pack_command(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
         issue_read(rand_anchor(FRAME_WIDTH), rand_anchor(FRAME_HEIGHT));
         if (phase == 0) begin
            run_strokes(60);
            squeeze_output();
            run_strokes(PHASE_WORDS - 80);
         end else begin
            run_strokes(PHASE_WORDS - 5);
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.awaited_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result sink: check accepted words, stall on a changing pattern
   initial begin : result_sink
      result_type  seen;
      rx_mode_type mode;
      int          mode_left, stall_left, tick, hold_off_done;
      mode          = RX_OPEN;
      mode_left     = 0;
      stall_left    = 0;
      tick          = 0;
      hold_off_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.ready === 1'b1 && rsp_bus.valid !== 1'b0) begin
            seen.dirty_left   = rsp_bus.dirty_left;
            seen.dirty_right  = rsp_bus.dirty_right;
            seen.dirty_top    = rsp_bus.dirty_top;
            seen.dirty_bottom = rsp_bus.dirty_bottom;
            seen.pixel_value  = rsp_bus.pixel_value;
            seen.has_drawing  = rsp_bus.has_drawing;
            board.check_result(seen);
         end
         if (hold_off_asked != hold_off_done) begin
            hold_off_done = hold_off_asked;
            stall_left    = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 400);
         end
         mode_left--;
         tick++;
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_bus.ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
hdl/tlr_pkg.sv
hdl/tlr_req_if.sv
hdl/tlr_rsp_if.sv
hdl/tlr_ram.sv
hdl/tlr_stamp.sv
hdl/thick_line_rasterizer.sv
verif/tb_thick_line_rasterizer.sv
